FILE: src/assert_macros.svh
// Assertion macros used by the statistics unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Widths and codes for the running mean and variance statistics unit.
// ----------------------------------------------------------------------------
package rmvs_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 32;
    localparam int VAL_W     = 32;
    localparam int SQ_W      = 64;
    localparam int BUSY_W    = 48;
    localparam int UTIL_W    = 17;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_BUSY   = 1'b1;
endpackage

FILE: src/running_mean_variance_stats.sv
// A sample passes through the 32-step mean division, the mean update, the
// product and the 64-step variance division; a busy increment starts at the
// variance division. Both then take a 32-step root and a 64-step utilization
// division before the result is offered; the block takes one item at a time.
// Input and configuration are not ready until the result has been taken.
// Reset (synchronous, active low) clears all statistics and the register.
// ----------------------------------------------------------------------------
// running_mean_variance_stats
// Welford online mean and variance with utilization, one shared serial unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module running_mean_variance_stats (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_total[31:0], mean_out[63:32], stddev_out[95:64],
    // utilization_out[112:96]
    output logic [119:0] m_tdata
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_MDIV, ST_MUPD, ST_PROD, ST_VDIV, ST_SQRT,
        ST_UDIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [47:0] total_reg;
    logic [31:0] count_reg, mean_reg, x_reg, d1_reg, sd_reg;
    logic [63:0] m2_reg;
    logic [47:0] busy_reg;
    logic        neg_reg;
    logic [63:0] num_reg, quo_reg, rem_reg, div_reg;
    logic [6:0]  step_reg;
    logic [63:0] rt_x_reg, rt_res_reg;
    logic [16:0] util_reg;

    logic [16:0] util_one;
    assign util_one = 17'd1 << rmvs_pkg::FRAC_BITS;

    // Shared restoring divider step.
    logic [64:0] rem_sh;
    logic        ge;
    assign rem_sh = {rem_reg, num_reg[63]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    logic [31:0] cnt_inc;
    assign cnt_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;

    logic [31:0] mean_new, d2;
    assign mean_new = neg_reg ? mean_reg - quo_reg[31:0] : mean_reg + quo_reg[31:0];
    assign d2 = neg_reg ? mean_new - x_reg : x_reg - mean_new;

    // x_reg holds the second deviation when the product is taken.
    logic [63:0] prod, m2_sum;
    logic        m2_ovf;
    assign prod = {32'd0, d1_reg} * {32'd0, x_reg};
    assign {m2_ovf, m2_sum} = {1'b0, m2_reg} + {1'b0, prod};

    // Square root bit pair step; step_reg counts 32 iterations.
    logic [63:0] rt_bit, rt_sum;
    assign rt_bit = 64'd1 << {step_reg[4:0], 1'b0};
    assign rt_sum = rt_res_reg + rt_bit;

    logic [48:0] busy_sum;
    assign busy_sum = {1'b0, busy_reg} + {17'd0, s_tdata};

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {7'd0, util_reg, sd_reg,
                        (count_reg == 32'd0) ? 32'd0 : mean_reg, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
            busy_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) total_reg <= cfg_data;
                    if (s_tvalid) begin
                        x_reg <= s_tdata;
                        if (s_tuser == rmvs_pkg::MODE_SAMPLE) begin
                            count_reg <= cnt_inc;
                            neg_reg   <= s_tdata < mean_reg;
                            d1_reg    <= (s_tdata < mean_reg) ? mean_reg - s_tdata
                                                              : s_tdata - mean_reg;
                            num_reg   <= {(s_tdata < mean_reg) ? mean_reg - s_tdata
                                                               : s_tdata - mean_reg, 32'd0};
                            div_reg   <= {32'd0, cnt_inc};
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            step_reg  <= 7'd32;
                            state_reg <= ST_MDIV;
                        end else begin
                            busy_reg  <= busy_sum[48] ? 48'hFFFF_FFFF_FFFF : busy_sum[47:0];
                            state_reg <= ST_VDIV;
                            num_reg   <= m2_reg;
                            div_reg   <= {32'd0, count_reg - 32'd1};
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            step_reg  <= 7'd64;
                        end
                    end
                end
                ST_MDIV, ST_VDIV, ST_UDIV: begin
                    rem_reg  <= ge ? rem_sh[63:0] - div_reg : rem_sh[63:0];
                    quo_reg  <= {quo_reg[62:0], ge};
                    num_reg  <= {num_reg[62:0], 1'b0};
                    step_reg <= step_reg - 7'd1;
                    if (step_reg == 7'd1) begin
                        if (state_reg == ST_MDIV) state_reg <= ST_MUPD;
                        else if (state_reg == ST_VDIV) begin
                            rt_x_reg   <= {quo_reg[62:0], ge};
                            rt_res_reg <= '0;
                            step_reg   <= 7'd31;
                            state_reg  <= ST_SQRT;
                        end else begin
                            util_reg  <= {1'b0, quo_reg[14:0], ge};
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_MUPD: begin
                    mean_reg  <= mean_new;
                    x_reg     <= d2;
                    state_reg <= ST_PROD;
                end
                ST_PROD: begin
                    m2_reg    <= m2_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum;
                    num_reg   <= m2_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum;
                    div_reg   <= {32'd0, count_reg - 32'd1};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= 7'd64;
                    state_reg <= ST_VDIV;
                end
                ST_SQRT: begin
                    if (rt_x_reg >= rt_sum) begin
                        rt_x_reg   <= rt_x_reg - rt_sum;
                        rt_res_reg <= (rt_res_reg >> 1) + rt_bit;
                    end else begin
                        rt_res_reg <= rt_res_reg >> 1;
                    end
                    step_reg <= step_reg - 7'd1;
                    if (step_reg == 7'd0) begin
                        state_reg <= ST_UDIV;
                        num_reg   <= 64'(busy_reg) << rmvs_pkg::FRAC_BITS;
                        div_reg   <= {16'd0, total_reg};
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        step_reg  <= 7'd48 + 7'(rmvs_pkg::FRAC_BITS);
                    end
                end
                ST_OUT: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_SQRT && step_reg == 7'd0) begin
                sd_reg <= (count_reg < 32'd2) ? 32'd0 :
                          ((rt_x_reg >= rt_sum) ? 32'((rt_res_reg >> 1) + rt_bit)
                                                : 32'(rt_res_reg >> 1));
            end
            if (state_reg == ST_UDIV && step_reg == 7'd1) begin
                if (total_reg == 48'd0) util_reg <= '0;
                else if (busy_reg >= total_reg) util_reg <= util_one;
            end
        end
    end

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result lost")
    `ASSERT_IMPL(a_busy_block, aclk, aresetn, state_reg != ST_IDLE, !s_tready && !cfg_ready, "ready")
    `ASSERT_IMPL(a_util_range, aclk, aresetn, m_tvalid, m_tdata[112:96] <= util_one, "util above one")
endmodule

FILE: verif/stats_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stats_checker
// Watches the configuration, input and result channels of the statistics
// unit, keeps its own copy of the running statistics and compares each
// result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module stats_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [47:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    output int           fail_count,
    output int           outstanding
);

    typedef struct packed {
        logic [rmvs_pkg::CNT_W-1:0]  count;
        logic [rmvs_pkg::VAL_W-1:0]  mean;
        logic [rmvs_pkg::VAL_W-1:0]  sdev;
        logic [rmvs_pkg::UTIL_W-1:0] util;
    } stats_t;

    localparam logic [63:0] CNT_MAX  = 64'hFFFF_FFFF;
    localparam logic [63:0] SQ_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] BUSY_MAX = 48'hFFFF_FFFF_FFFF;

    stats_t      expected_q[$];
    logic [47:0] duration;
    logic [63:0] n_samples;
    logic [63:0] mean_acc;
    logic [63:0] sq_sum;
    logic [47:0] busy;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [rmvs_pkg::UTIL_W-1:0] busy_ratio(input logic [47:0] num,
                                                                input logic [47:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        if (den == 0)
            return '0;
        if (num >= den)
            return rmvs_pkg::UTIL_W'(1) << rmvs_pkg::FRAC_BITS;
        rem = {16'd0, num};
        q   = 0;
        for (int i = 0; i < rmvs_pkg::FRAC_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= {16'd0, den}) begin
                rem = rem - {16'd0, den};
                q   = q | 64'd1;
            end
        end
        return q[rmvs_pkg::UTIL_W-1:0];
    endfunction

    // Applies one input item to the predicted statistics and returns the result.
    function automatic stats_t absorb_item(input logic mode, input logic [31:0] v);
        logic [63:0] x;
        logic [63:0] old_mean;
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] prod;
        logic [63:0] root;
        logic [48:0] busy_sum;
        stats_t      r;
        x = {32'd0, v};
        if (mode == rmvs_pkg::MODE_SAMPLE) begin
            if (n_samples < CNT_MAX)
                n_samples = n_samples + 64'd1;
            old_mean = mean_acc;
            if (x >= old_mean) begin
                d1       = x - old_mean;
                mean_acc = old_mean + d1 / n_samples;
                d2       = x - mean_acc;
            end else begin
                d1       = old_mean - x;
                mean_acc = old_mean - d1 / n_samples;
                d2       = mean_acc - x;
            end
            mean_acc = mean_acc & CNT_MAX;
            prod     = d1 * d2;
            if (sq_sum > SQ_MAX - prod)
                sq_sum = SQ_MAX;
            else
                sq_sum = sq_sum + prod;
        end else begin
            busy_sum = {1'b0, busy} + {17'd0, v};
            busy     = (busy_sum > {1'b0, BUSY_MAX}) ? BUSY_MAX : busy_sum[47:0];
        end
        root    = (n_samples >= 64'd2) ? int_sqrt(sq_sum / (n_samples - 64'd1)) : 64'd0;
        r.count = n_samples[31:0];
        r.mean  = (n_samples == 0) ? '0 : mean_acc[31:0];
        r.sdev  = root[31:0];
        r.util  = busy_ratio(busy, duration);
        return r;
    endfunction

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        stats_t want;
        if (!aresetn) begin
            expected_q.delete();
            duration   = '0;
            n_samples  = '0;
            mean_acc   = '0;
            sq_sum     = '0;
            busy       = '0;
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", m_tdata[63:0], 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[31:0] !== want.count)
                        report("sample_total", {32'd0, m_tdata[31:0]}, {32'd0, want.count});
                    if (m_tdata[63:32] !== want.mean)
                        report("mean_out", {32'd0, m_tdata[63:32]}, {32'd0, want.mean});
                    if (m_tdata[95:64] !== want.sdev)
                        report("stddev_out", {32'd0, m_tdata[95:64]}, {32'd0, want.sdev});
                    if (m_tdata[112:96] !== want.util)
                        report("utilization_out", {47'd0, m_tdata[112:96]},
                               {47'd0, want.util});
                end
            end
            if (cfg_valid && cfg_ready)
                duration = cfg_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(absorb_item(s_tuser, s_tdata));
        end
        outstanding = expected_q.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and busy increments into the statistics unit under several
// total-duration settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [47:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // value[31:0]
    logic         s_tuser;   // mode[0]
    logic         m_tvalid;
    logic         m_tready;
    // sample_total[31:0], mean_out[63:32], stddev_out[95:64],
    // utilization_out[112:96]
    logic [119:0] m_tdata;
    int           fail_count;
    int           outstanding;
    int           burst_left;
    int           stall_style;
    int           stall_timer;

    running_mean_variance_stats dut (.*);

    stats_checker checker_i (.*);

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The result side switches at random between always ready, random and rarely ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_timer <= 0;
            stall_style <= 0;
        end else begin
            if (stall_timer == 0) begin
                stall_timer <= $urandom_range(100, 800);
                stall_style <= $urandom_range(0, 2);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_duration(input logic [47:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic mode, input logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Lets every result come back, then leaves room for the block to settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_sample;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h0010_0000 + $urandom_range(0, 32'h0004_0000);
            2: return $urandom_range(0, 32'h0001_0000);
            3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: return 32'h0800_0000 + $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_busy;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0004_0000);
    endfunction

    initial begin
        logic [47:0] durations[5];
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= rmvs_pkg::MODE_SAMPLE;
        aresetn    <= 1'b0;
        burst_left = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty statistics, zero total, then value extremes.
        send_item(rmvs_pkg::MODE_BUSY, 32'd0);
        send_item(rmvs_pkg::MODE_SAMPLE, 32'd0);
        send_item(rmvs_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
        send_item(rmvs_pkg::MODE_SAMPLE, 32'h0001_0000);
        send_item(rmvs_pkg::MODE_BUSY, 32'h0001_0000);
        drain();
        write_duration(48'd1);
        send_item(rmvs_pkg::MODE_BUSY, 32'd0);
        send_item(rmvs_pkg::MODE_SAMPLE, 32'h0002_0000);
        drain();
        write_duration(48'hFFFF_FFFF_FFFF);
        send_item(rmvs_pkg::MODE_BUSY, 32'hFFFF_FFFF);
        send_item(rmvs_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
        drain();
        // Busy equal to the total gives exactly one.
        write_duration(48'h0001_0001_FFFE);
        send_item(rmvs_pkg::MODE_BUSY, 32'h0000_FFFF);
        drain();

        durations[0] = 48'($urandom_range(1, 32'h00FF_FFFF));
        durations[1] = 48'hFFFF_FFFF_FFFF;
        durations[2] = {16'($urandom_range(0, 16'hFFFF)), $urandom};
        durations[3] = 48'd0;
        durations[4] = 48'($urandom_range(32'h0010_0000, 32'h4000_0000));
        foreach (durations[p]) begin
            write_duration(durations[p]);
            for (int i = 0; i < 185; i++) begin
                if ($urandom_range(0, 2) != 0)
                    send_item(rmvs_pkg::MODE_SAMPLE, pick_sample());
                else
                    send_item(rmvs_pkg::MODE_BUSY, pick_busy());
            end
            drain();
        end

        // Alternating extremes drive the squared-deviation sum into saturation.
        for (int i = 0; i < 12; i++)
            send_item(rmvs_pkg::MODE_SAMPLE, i[0] ? 32'd0 : 32'hFFFF_FFFF);
        send_item(rmvs_pkg::MODE_SAMPLE, 32'h1234_5678);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
